>>> rtl/core/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// shared types and codes of the beacon sighting table
// ----------------------------------------------------------------------------
package bst_pkg;

  // default table depth
  localparam int TABLE_ROWS_DEF = 128;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // field widths of one item and one result
  localparam int MODE_W   = 2;
  localparam int ID_W     = 32;
  localparam int TIME_W   = 16;
  localparam int RROW_W   = 7;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = 7;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SIGHT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_READ     = 3'd5;

  // operation classes handed from front to back
  typedef enum logic [1:0] {
    OP_SIGHT,
    OP_CLEAR,
    OP_READ,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   beacon_id;
    logic [TIME_W-1:0] sight_time;
    logic [RROW_W-1:0] read_row;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    row_index;
    logic                row_used;
    logic [ID_W-1:0]     row_id;
    logic [TIME_W-1:0]   row_first_seen;
    logic [TIME_W-1:0]   row_last_seen;
  } result_t;

endpackage

>>> rtl/core/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front
// takes input transfers and sorts them into operation classes
// ----------------------------------------------------------------------------
module bst_front
  import bst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [55:0]         s_tdata,
  input  logic [MODE_W-1:0]   s_tuser,
  input  logic                q_full,
  output logic                q_push,
  output item_t               q_item
);

  logic [ID_W-1:0]   beacon_id;
  logic [TIME_W-1:0] sight_time;
  logic [RROW_W-1:0] read_row;
  logic              rst_q;

  assign beacon_id  = s_tdata[31:0];
  assign sight_time = s_tdata[47:32];
  assign read_row   = s_tdata[54:48];

  // hold off for the cycle after reset so the queue is settled
  always_ff @(posedge clk) begin
    rst_q <= rst;
  end

  assign s_tready = !q_full && !rst && !rst_q;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_item.beacon_id  = beacon_id;
    q_item.sight_time = sight_time;
    q_item.read_row   = read_row;
    case (s_tuser)
      MODE_SIGHT: q_item.op = (beacon_id == '0) ? OP_IGNORE : OP_SIGHT;
      MODE_CLEAR: q_item.op = OP_CLEAR;
      MODE_READ:  q_item.op = OP_READ;
      default:    q_item.op = OP_IGNORE;
    endcase
  end

endmodule

>>> rtl/core/bst_queue.sv
// ----------------------------------------------------------------------------
// bst_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module bst_queue
  import bst_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bst_back.sv
// ----------------------------------------------------------------------------
// bst_back
// row store, lookup walk, insert, clear and read back
// ----------------------------------------------------------------------------
module bst_back
  import bst_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  item_t   q_item,
  output logic    q_pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  localparam int ROW_W  = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
  localparam int CNT_W  = $clog2(TABLE_ROWS + 1);
  localparam int CMP_W  = (CNT_W > RROW_W) ? CNT_W : RROW_W;
  localparam int WORD_W = ID_W + 2 * TIME_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [WORD_W-1:0] mem [TABLE_ROWS];
  logic [WORD_W-1:0] mem_q;

  logic [1:0]        state;
  logic [CNT_W-1:0]  rows_filled;
  logic [CNT_W-1:0]  ptr;
  logic              chk_valid;
  logic [ROW_W-1:0]  chk_row;
  item_t             cur;

  logic              rd_en;
  logic [ROW_W-1:0]  rd_addr;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              res_load;
  result_t           res_next;
  logic              hit;
  logic              read_ok;

  function automatic logic [IDX_W-1:0] to_idx(input logic [ROW_W-1:0] r);
    logic [ROW_W+IDX_W-1:0] ext;
    ext = {{IDX_W{1'b0}}, r};
    return ext[IDX_W-1:0];
  endfunction

  // row store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  assign q_pop   = (state == S_IDLE) && q_valid && (!out_valid || out_ready);
  assign hit     = chk_valid && (mem_q[WORD_W-1:2*TIME_W] == cur.beacon_id);
  assign read_ok = CMP_W'(cur.read_row) < CMP_W'(rows_filled);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = ptr[ROW_W-1:0];
    wr_en    = 1'b0;
    wr_addr  = chk_row;
    wr_data  = {cur.beacon_id, cur.sight_time, cur.sight_time};
    res_load = 1'b0;
    res_next = '0;
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          case (q_item.op)
            OP_CLEAR: begin
              res_load        = 1'b1;
              res_next.status = STAT_CLEARED;
            end
            OP_READ: begin
              rd_en   = 1'b1;
              rd_addr = ROW_W'(q_item.read_row);
            end
            OP_SIGHT: begin
            end
            default: begin
              res_load        = 1'b1;
              res_next.status = STAT_IGNORED;
            end
          endcase
        end
      end
      S_READ: begin
        res_load           = 1'b1;
        res_next.status    = STAT_READ;
        res_next.row_index = cur.read_row;
        if (read_ok) begin
          res_next.row_used       = 1'b1;
          res_next.row_id         = mem_q[WORD_W-1:2*TIME_W];
          res_next.row_first_seen = mem_q[2*TIME_W-1:TIME_W];
          res_next.row_last_seen  = mem_q[TIME_W-1:0];
        end
      end
      S_SCAN: begin
        if (hit) begin
          wr_en              = 1'b1;
          wr_addr            = chk_row;
          wr_data            = {mem_q[WORD_W-1:TIME_W], cur.sight_time};
          res_load           = 1'b1;
          res_next.status    = STAT_UPDATED;
          res_next.row_index = to_idx(chk_row);
        end else if (ptr < rows_filled) begin
          rd_en   = 1'b1;
          rd_addr = ptr[ROW_W-1:0];
        end else if (!chk_valid) begin
          res_load = 1'b1;
          if (rows_filled >= CNT_W'(TABLE_ROWS)) begin
            res_next.status = STAT_FULL;
          end else begin
            wr_en              = 1'b1;
            wr_addr            = rows_filled[ROW_W-1:0];
            res_next.status    = STAT_INSERTED;
            res_next.row_index = to_idx(rows_filled[ROW_W-1:0]);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (res_load) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rows_filled <= '0;
      ptr         <= '0;
      chk_valid   <= 1'b0;
      chk_row     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.op)
              OP_SIGHT: begin
                ptr       <= '0;
                chk_valid <= 1'b0;
                state     <= S_SCAN;
              end
              OP_CLEAR: rows_filled <= '0;
              OP_READ:  state       <= S_READ;
              default: begin
              end
            endcase
          end
        end
        S_READ: state <= S_IDLE;
        S_SCAN: begin
          if (hit) begin
            state <= S_IDLE;
          end else if (ptr < rows_filled) begin
            chk_valid <= 1'b1;
            chk_row   <= ptr[ROW_W-1:0];
            ptr       <= ptr + 1'b1;
          end else if (chk_valid) begin
            chk_valid <= 1'b0;
          end else begin
            if (rows_filled < CNT_W'(TABLE_ROWS)) begin
              rows_filled <= rows_filled + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/beacon_sighting_table.sv
// ----------------------------------------------------------------------------
// beacon_sighting_table
// lookup-or-insert table of seen beacons with first and last sighting times
// ----------------------------------------------------------------------------
//
// channel  dir  tdata (lowest bit up)                          tuser
// s_*      in   beacon_id 32, sight_time 16, read_row 7, pad 1  mode 2
// m_*      out  row_index 7, row_used 1, row_id 32,             status 3
//               row_first_seen 16, row_last_seen 16
//
// a sighting walks the used rows one per store read, then updates the
// matching row or appends one if not full; clear and ignored items give
// their result from idle, a read back goes through the read state
// rst is synchronous; the table empties at once because only the fill
// count is cleared, and the input side is held off while rst is high and
// in the cycle after it
// the two-entry queue keeps taking transfers, until it is full, while the
// back end walks the table or a result waits in the output register
//
module beacon_sighting_table
  import bst_pkg::*;
#(
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input transfers
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [55:0]         s_tdata,  // beacon_id, sight_time, read_row, pad
  input  logic [MODE_W-1:0]   s_tuser,  // mode
  // result transfers
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [71:0]         m_tdata,  // row_index, row_used, row_id, first, last
  output logic [STATUS_W-1:0] m_tuser   // status
);

  // front to queue
  logic    q_push;
  item_t   q_in;
  logic    q_full;

  // queue to back
  logic    q_pop;
  logic    q_valid;
  item_t   q_head;

  result_t res;

  // front end: classify incoming transfers
  bst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // decoupling queue
  bst_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // back end: table store and lookup walk, result register
  bst_back #(
    .TABLE_ROWS (TABLE_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result packing, lowest field first
  assign m_tdata = {res.row_last_seen, res.row_first_seen, res.row_id,
                    res.row_used, res.row_index};
  assign m_tuser = res.status;

endmodule
